[hdl/brfr_pkg.sv]
// Package for the bounded request FIFO with removal.
// Holds the command and status codes, the word types of both channels and the cell control.
// No dependencies.
package brfr_pkg;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_PEEK   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_EMPTY    = 2'd2,
        STAT_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_ROTATE = 1'b1
    } t_state;

    localparam int CAP_W     = 7;
    localparam int CAP_RESET = 64;

    typedef struct packed {
        t_cmd        cmd;
        logic [15:0] value;
    } t_cmd_word;

    typedef struct packed {
        t_status     status;
        logic [15:0] popped_value;
        logic [15:0] head_value;
        logic        head_valid;
        logic [6:0]  count;
    } t_result_word;

    // Per-cell control: load a new word, or take the word of the next cell.
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

[hdl/brfr_cell.sv]
// One storage cell of the queue chain.
// Depends on brfr_pkg for the cell control struct.
module brfr_cell #(
    parameter int VALUE_BITS = 16
) (
    input  logic                  i_clk,
    input  brfr_pkg::t_cell_ctl   i_ctl,
    input  logic [VALUE_BITS-1:0] i_load_data,
    input  logic [VALUE_BITS-1:0] i_next_data,
    output logic [VALUE_BITS-1:0] o_data
);
    import brfr_pkg::*;

    logic [VALUE_BITS-1:0] r_data;
    logic [VALUE_BITS-1:0] n_data;

    // A load wins over a shift: during a rotation the old head lands at the tail.
    always_comb begin
        n_data = r_data;
        if (i_ctl.load) begin
            n_data = i_load_data;
        end else if (i_ctl.shift) begin
            n_data = i_next_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

[hdl/bounded_request_fifo_with_removal_core.sv]
// Bounded request FIFO with removal: push, pop and peek need no busy phase, and a new word can
// be started every cycle while busy is low; the result word appears in the cycle after acceptance.
// Remove rotates the whole chain once through its head, one cell step per cycle, so it keeps
// busy high until every entry has passed the head, and reports in the cycle after the last step.
// Reset is synchronous and active low: the queue is empty and capacity returns to 64.
// Results are shown for exactly one cycle with o_valid; the receiver cannot stall them.
module bounded_request_fifo_with_removal_core #(
    parameter int DEPTH      = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  brfr_pkg::t_cmd_word         i_cmd,
    output logic                        o_valid,
    output brfr_pkg::t_result_word      o_result,
    input  logic                        i_cfg_we,
    input  logic [brfr_pkg::CAP_W-1:0]  i_cfg_data
);
    import brfr_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    // Control state.
    t_state                r_state,    n_state;
    logic [CNT_W-1:0]      r_count,    n_count;
    logic [CNT_W-1:0]      r_left,     n_left;
    logic                  r_found,    n_found;
    logic                  r_valid,    n_valid;
    logic [CAP_W-1:0]      r_capacity;

    // Payload registers, no reset needed.
    logic [VALUE_BITS-1:0] r_key,      n_key;
    t_status               r_status,   n_status;
    logic [15:0]           r_popped,   n_popped;

    // Chain signals.
    logic [VALUE_BITS-1:0] w_cell_q [DEPTH];
    logic                  w_shift_all;
    logic                  w_load_en;
    logic [CNT_W-1:0]      w_load_idx;
    logic [VALUE_BITS-1:0] w_load_data;

    logic                  w_accept;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_hit;
    logic [31:0]           w_in32;
    logic [31:0]           w_head32;
    logic [VALUE_BITS-1:0] w_key_in;
    logic [VALUE_BITS-1:0] w_head;

    assign w_in32   = 32'(i_cmd.value);
    assign w_key_in = w_in32[VALUE_BITS-1:0];
    assign w_head   = w_cell_q[0];
    assign w_head32 = 32'(w_head);

    assign busy     = (r_state == ST_ROTATE);
    assign w_accept = start && !busy;
    assign w_empty  = (r_count == '0);

    // The effective limit is the smaller of the capacity register and the depth.
    assign w_full = (32'(r_count) >= 32'(r_capacity)) || (32'(r_count) >= DEPTH);

    // During a rotation only the first matching word is dropped.
    assign w_hit = !r_found && (w_head == r_key);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_left      = r_left;
        n_found     = r_found;
        n_key       = r_key;
        n_status    = r_status;
        n_popped    = r_popped;
        n_valid     = 1'b0;
        w_shift_all = 1'b0;
        w_load_en   = 1'b0;
        w_load_idx  = r_count;
        w_load_data = w_key_in;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_popped = '0;
                    unique case (i_cmd.cmd)
                        CMD_PUSH: begin
                            n_valid = 1'b1;
                            if (w_full) begin
                                n_status = STAT_FULL;
                            end else begin
                                n_status  = STAT_OK;
                                w_load_en = 1'b1;
                                n_count   = r_count + 1'b1;
                            end
                        end
                        CMD_POP: begin
                            n_valid = 1'b1;
                            if (w_empty) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                n_status    = STAT_OK;
                                n_popped    = w_head32[15:0];
                                w_shift_all = 1'b1;
                                n_count     = r_count - 1'b1;
                            end
                        end
                        CMD_REMOVE: begin
                            if (w_empty) begin
                                n_valid  = 1'b1;
                                n_status = STAT_EMPTY;
                            end else begin
                                n_state = ST_ROTATE;
                                n_left  = r_count;
                                n_found = 1'b0;
                                n_key   = w_key_in;
                            end
                        end
                        CMD_PEEK: begin
                            n_valid  = 1'b1;
                            n_status = w_empty ? STAT_EMPTY : STAT_OK;
                        end
                        default: begin
                            n_valid = 1'b0;
                        end
                    endcase
                end
            end
            ST_ROTATE: begin
                // Every cell takes its neighbor's word; the old head goes back in at the
                // tail unless it is the word being removed.
                w_shift_all = 1'b1;
                if (w_hit) begin
                    n_found = 1'b1;
                    n_count = r_count - 1'b1;
                end else begin
                    w_load_en   = 1'b1;
                    w_load_idx  = r_count - 1'b1;
                    w_load_data = w_head;
                end
                n_left = r_left - 1'b1;
                if (r_left == CNT_W'(1)) begin
                    n_state  = ST_IDLE;
                    n_valid  = 1'b1;
                    n_status = (r_found || w_hit) ? STAT_OK : STAT_NOTFOUND;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_left     <= '0;
            r_found    <= 1'b0;
            r_valid    <= 1'b0;
            r_capacity <= CAP_W'(CAP_RESET);
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
            r_found <= n_found;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_status <= n_status;
        r_popped <= n_popped;
    end

    // The chain of storage cells, oldest word in cell 0.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell_ctl             w_ctl;
        logic [VALUE_BITS-1:0] w_next;

        assign w_ctl.shift = w_shift_all;
        assign w_ctl.load  = w_load_en && (w_load_idx == CNT_W'(g));

        if (g == DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_cell_q[g+1];
        end

        brfr_cell #(
            .VALUE_BITS(VALUE_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_load_data (w_load_data),
            .i_next_data (w_next),
            .o_data      (w_cell_q[g])
        );
    end

    // The result word describes the queue after the command, straight from the registers.
    always_comb begin
        o_result.status       = r_status;
        o_result.popped_value = r_popped;
        o_result.head_valid   = !w_empty;
        o_result.head_value   = w_empty ? 16'd0 : w_head32[15:0];
        o_result.count        = 7'(r_count);
    end

    assign o_valid = r_valid;

    // The fill level never passes the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= DEPTH)
        else $error("fill level above depth");

    // Push, pop and peek report in the very next cycle.
    a_fast_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_cmd.cmd != CMD_REMOVE) |=> r_valid)
        else $error("missing result after a single cycle command");

    // A rotation drops at most one word and always has steps left.
    a_rotate_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROTATE) |-> (r_left != '0))
        else $error("rotation with no steps left");

    a_single_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROTATE && r_found) |-> !w_load_en || !w_hit)
        else $error("second word dropped in one removal");

    // A result leaves no rotation running.
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == ST_IDLE))
        else $error("result shown while still rotating");

endmodule
